[hw/rtl/gld_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gld_pkg
// Shared constants and controller/datapath interface types for the GIF LZW
// decoder.
// ----------------------------------------------------------------------------
package gld_pkg;

  localparam int MaxCodeBits = 12;
  localparam int TableSize   = 1 << MaxCodeBits;
  localparam int SlotBits    = MaxCodeBits + 1;
  localparam int BufBits     = 2 * MaxCodeBits;

  localparam logic [1:0] ACT_PUSH    = 2'd0;
  localparam logic [1:0] ACT_PULL    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [2:0] ST_PIXEL     = 3'd0;
  localparam logic [2:0] ST_ACCEPTED  = 3'd1;
  localparam logic [2:0] ST_REFUSED   = 3'd2;
  localparam logic [2:0] ST_NEED_BYTE = 3'd3;
  localparam logic [2:0] ST_END       = 3'd4;
  localparam logic [2:0] ST_BAD_CODE  = 3'd5;
  localparam logic [2:0] ST_RESTARTED = 3'd6;

  typedef struct packed {
    logic       push_byte;   // stream byte request
    logic       restart;
    logic       do_clear;    // consume clear code, reset dictionary
    logic       set_end;     // consume end code
    logic       set_fail;    // consume bad code
    logic       start_code;  // consume data code, begin chain walk
    logic       walk_step;
    logic       finish;
    logic       pop;         // read top of stack, decrement depth
    logic       out_load;
    logic [2:0] out_status;
    logic       out_from_stack;
  } gld_cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic failed;
    logic ended;
    logic enough;
    logic is_end;
    logic is_clear;
    logic is_bad;
    logic walk_more;
    logic out_free;
  } gld_stat_t;

endpackage
`default_nettype wire

[hw/rtl/gld_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gld_ctrl
// Sequencer for the decoder: request intake, code fetch, chain walk and pop.
// ----------------------------------------------------------------------------
module gld_ctrl import gld_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic [1:0] action_i,
  input  wire gld_stat_t stat_i,
  output gld_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_WALK,
    S_POPA,
    S_POPB
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_PUSH: cmd_o.push_byte = 1'b1;
            ACT_RESTART: begin
              cmd_o.restart    = 1'b1;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = ST_RESTARTED;
            end
            ACT_PULL: begin
              if (!stat_i.stack_empty) begin
                cmd_o.pop = 1'b1;
                state_d   = S_POPB;
              end else if (stat_i.failed) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_BAD_CODE;
              end else if (stat_i.ended) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_END;
              end else begin
                state_d = S_FETCH;
              end
            end
            default: ;  // unused action: drop
          endcase
        end
      end
      S_FETCH: begin
        if (!stat_i.enough) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_NEED_BYTE;
          state_d          = S_IDLE;
        end else if (stat_i.is_end) begin
          cmd_o.set_end    = 1'b1;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_END;
          state_d          = S_IDLE;
        end else if (stat_i.is_clear) begin
          cmd_o.do_clear = 1'b1;
        end else if (stat_i.is_bad) begin
          cmd_o.set_fail   = 1'b1;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_BAD_CODE;
          state_d          = S_IDLE;
        end else begin
          cmd_o.start_code = 1'b1;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.walk_more) begin
          cmd_o.walk_step = 1'b1;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_POPA;
        end
      end
      S_POPA: begin
        cmd_o.pop = 1'b1;
        state_d   = S_POPB;
      end
      S_POPB: begin
        cmd_o.out_load       = 1'b1;
        cmd_o.out_status     = ST_PIXEL;
        cmd_o.out_from_stack = 1'b1;
        state_d              = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> !stat_i.stack_empty)
    else $error("pop from empty stack");
  a_finish_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !stat_i.stack_empty)
    else $error("stack empty after code finished");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result overwrites pending result");
`endif

endmodule
`default_nettype wire

[hw/rtl/gld_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gld_dpath
// Bit buffer, dictionary and stack memories, decoder state and result register.
// ----------------------------------------------------------------------------
module gld_dpath import gld_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       cfg_valid_i,
  input  wire logic [3:0] min_code_size_i,
  input  wire gld_cmd_t   cmd_i,
  output gld_stat_t       stat_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      pixel_o,
  output logic [2:0]      status_o
);

  logic [7:0]             suffix_mem [TableSize];
  logic [MaxCodeBits-1:0] prefix_mem [TableSize];
  logic [7:0]             stack_mem  [TableSize];

  logic [3:0]             cfg_q, root_q, width_q, root_sat;
  logic [BufBits-1:0]     buf_q, buf_d;
  logic [4:0]             bits_q, bits_d;
  logic [7:0]             blk_q, blk_d;
  logic [SlotBits-1:0]    slot_q, slot_d, limit_q, limit_d, depth_q, depth_d;
  logic [3:0]             width_d;
  logic                   have_prev_q, have_prev_d;
  logic [MaxCodeBits-1:0] prev_q, prev_d, code_q, code_d, cur_q, cur_d;
  logic [7:0]             first_q, first_d;
  logic                   ended_q, ended_d, failed_q, failed_d;
  logic                   out_valid_q;
  logic [7:0]             suffix_rd_q, stack_rd_q;
  logic [MaxCodeBits-1:0] prefix_rd_q;

  logic [BufBits-1:0]     mask;
  logic [MaxCodeBits-1:0] code_c;
  logic [SlotBits-1:0]    clr_code, first_free, root_clear;
  logic                   kwk, push_ok, stk_we, add, out_free;
  logic [7:0]             stk_wdata;
  logic [2:0]             push_status;

  assign root_sat   = (cfg_q < 4'd2) ? 4'd2 : ((cfg_q > 4'd8) ? 4'd8 : cfg_q);
  assign clr_code   = SlotBits'(1) << root_q;
  assign first_free = clr_code + SlotBits'(2);
  assign mask       = (BufBits'(1) << width_q) - BufBits'(1);
  assign code_c     = MaxCodeBits'(buf_q & mask);
  assign kwk        = ({1'b0, code_c} == slot_q) && have_prev_q;
  assign push_ok    = (blk_q != 8'd0) && (bits_q < 5'd16);
  assign add        = (slot_q < limit_q) && have_prev_q && (slot_q < SlotBits'(TableSize));
  assign out_free   = !out_valid_q || out_ready_i;
  assign root_clear = SlotBits'(1) << root_sat;

  assign stat_o.stack_empty = (depth_q == '0);
  assign stat_o.failed      = failed_q;
  assign stat_o.ended       = ended_q;
  assign stat_o.enough      = bits_q >= {1'b0, width_q};
  assign stat_o.is_end      = {1'b0, code_c} == clr_code + SlotBits'(1);
  assign stat_o.is_clear    = {1'b0, code_c} == clr_code;
  assign stat_o.is_bad      = !kwk && ({1'b0, code_c} >= slot_q);
  assign stat_o.walk_more   = ({1'b0, cur_q} >= first_free) &&
                              (depth_q < SlotBits'(TableSize));
  assign stat_o.out_free    = out_free;

  // stack write source
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = suffix_rd_q;
    if (cmd_i.start_code && kwk) begin
      stk_we    = 1'b1;
      stk_wdata = first_q;
    end else if (cmd_i.walk_step) begin
      stk_we = 1'b1;
    end else if (cmd_i.finish) begin
      stk_we    = 1'b1;
      stk_wdata = cur_q[7:0];
    end
  end

  always_comb begin
    buf_d       = buf_q;
    bits_d      = bits_q;
    blk_d       = blk_q;
    width_d     = width_q;
    slot_d      = slot_q;
    limit_d     = limit_q;
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    first_d     = first_q;
    depth_d     = depth_q;
    ended_d     = ended_q;
    failed_d    = failed_q;
    code_d      = code_q;
    cur_d       = cur_q;
    push_status = ST_ACCEPTED;

    if (cmd_i.push_byte) begin
      if (blk_q == 8'd0) begin
        blk_d = data_byte_i;
      end else if (!push_ok) begin
        push_status = ST_REFUSED;
      end else begin
        buf_d  = buf_q | (BufBits'(data_byte_i) << bits_q);
        bits_d = bits_q + 5'd8;
        blk_d  = blk_q - 8'd1;
      end
    end

    if (cmd_i.do_clear || cmd_i.set_end || cmd_i.set_fail || cmd_i.start_code) begin
      buf_d  = buf_q >> width_q;
      bits_d = bits_q - {1'b0, width_q};
    end
    if (cmd_i.do_clear) begin
      width_d     = root_q + 4'd1;
      slot_d      = clr_code + SlotBits'(2);
      limit_d     = SlotBits'(1) << (root_q + 4'd1);
      have_prev_d = 1'b0;
      prev_d      = '0;
      first_d     = '0;
    end
    if (cmd_i.set_end)  ended_d  = 1'b1;
    if (cmd_i.set_fail) failed_d = 1'b1;
    if (cmd_i.start_code) begin
      code_d = code_c;
      cur_d  = kwk ? prev_q : code_c;
    end
    if (cmd_i.walk_step) cur_d = prefix_rd_q;

    if (cmd_i.finish) begin
      if (add) slot_d = slot_q + SlotBits'(1);
      first_d     = cur_q[7:0];
      prev_d      = code_q;
      have_prev_d = 1'b1;
      if ((slot_d >= limit_q) && (width_q < 4'(MaxCodeBits))) begin
        limit_d = limit_q << 1;
        width_d = width_q + 4'd1;
      end
    end

    if (stk_we && (depth_q < SlotBits'(TableSize))) depth_d = depth_q + SlotBits'(1);
    if (cmd_i.pop) depth_d = depth_q - SlotBits'(1);

    if (cmd_i.restart) begin
      width_d     = root_sat + 4'd1;
      slot_d      = root_clear + SlotBits'(2);
      limit_d     = SlotBits'(1) << (root_sat + 4'd1);
      have_prev_d = 1'b0;
      prev_d      = '0;
      first_d     = '0;
      buf_d       = '0;
      bits_d      = '0;
      blk_d       = '0;
      depth_d     = '0;
      ended_d     = 1'b0;
      failed_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= 4'd8;
      root_q      <= 4'd8;
      width_q     <= 4'd9;
      buf_q       <= '0;
      bits_q      <= '0;
      blk_q       <= '0;
      slot_q      <= SlotBits'(258);
      limit_q     <= SlotBits'(512);
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      first_q     <= '0;
      depth_q     <= '0;
      ended_q     <= 1'b0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) cfg_q <= min_code_size_i;
      if (cmd_i.restart) root_q <= root_sat;
      width_q     <= width_d;
      buf_q       <= buf_d;
      bits_q      <= bits_d;
      blk_q       <= blk_d;
      slot_q      <= slot_d;
      limit_q     <= limit_d;
      have_prev_q <= have_prev_d;
      prev_q      <= prev_d;
      first_q     <= first_d;
      depth_q     <= depth_d;
      ended_q     <= ended_d;
      failed_q    <= failed_d;
      if (cmd_i.push_byte || cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and memories
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    cur_q  <= cur_d;
    if (cmd_i.push_byte) begin
      pixel_o  <= 8'd0;
      status_o <= push_status;
    end else if (cmd_i.out_load) begin
      pixel_o  <= cmd_i.out_from_stack ? stack_rd_q : 8'd0;
      status_o <= cmd_i.out_status;
    end
    if (cmd_i.finish && add) begin
      suffix_mem[slot_q[MaxCodeBits-1:0]] <= cur_q[7:0];
      prefix_mem[slot_q[MaxCodeBits-1:0]] <= prev_q;
    end
    suffix_rd_q <= suffix_mem[cur_d];
    prefix_rd_q <= prefix_mem[cur_d];
    if (stk_we && (depth_q < SlotBits'(TableSize))) begin
      stack_mem[depth_q[MaxCodeBits-1:0]] <= stk_wdata;
    end
    stack_rd_q <= stack_mem[depth_d[MaxCodeBits-1:0]];
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= SlotBits'(TableSize))
    else $error("stack depth overflow");
  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= 5'd23)
    else $error("bit buffer overflow");
  a_width_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_q >= 4'd3 && width_q <= 4'(MaxCodeBits))
    else $error("code width out of range");
`endif

endmodule
`default_nettype wire

[hw/rtl/gif_lzw_decoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gif_lzw_decoder_top
// GIF variable-width LZW decoder, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes requests: push a stream
//   byte (sub-block length or code data), pull one pixel, or restart.
//   Output channel (out_valid_o/out_ready_i) returns one pixel/status per
//   request; unused action code 3 returns nothing.
//   Push and restart: response registered at the accept edge, one request
//   per cycle while the receiver keeps up. Non-empty stack pull: pop, then
//   result. Decoding pull: accept, a fetch step per clear code and one for
//   the code, a walk step per chain entry (dictionary read port, one entry a
//   cycle), then finish, pop and result.
//   The config channel (cfg_valid_i) writes min_code_size; it takes effect
//   at restart. Write it only while idle.
//   Reset: min code size 8, empty bit buffer and stack, next byte a length.
//   A stalled receiver holds the result; a new request is taken once the
//   pending result is being taken.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_top import gld_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      pixel_o,
  output logic [2:0]      status_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [3:0] min_code_size_i
);

  gld_cmd_t  cmd;
  gld_stat_t stat;

  assign cfg_ready_o = 1'b1;

  gld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gld_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (data_byte_i),
    .cfg_valid_i     (cfg_valid_i),
    .min_code_size_i (min_code_size_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_o         (pixel_o),
    .status_o        (status_o)
  );

endmodule
`default_nettype wire

[verif/gif_lzw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_checker
// Watches the request, response and config channels of the GIF LZW decoder,
// predicts every response from its own copy of the decoder state and
// compares pixel and status in order.
// ----------------------------------------------------------------------------
module gif_lzw_checker import gld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] pixel_i,
  input  logic [2:0] status_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [3:0] min_code_size_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] pixel;
    logic [2:0] status;
  } resp_t;

  resp_t      resp_q[$];
  logic [3:0] min_size;
  logic [23:0] bit_buf;
  int         bits_held;
  int         block_left;
  int         root_bits;
  int         code_width;
  int         next_slot;
  int         slot_limit;
  logic       have_prev;
  int         prev_code;
  logic [7:0] first_char;
  logic [7:0] suffix_mem [TableSize];
  logic [11:0] prefix_mem [TableSize];
  logic [7:0] pixel_stack [TableSize];
  int         stack_depth;
  logic       ended;
  logic       failed;

  function automatic void dict_clear();
    code_width = root_bits + 1;
    next_slot  = (1 << root_bits) + 2;
    slot_limit = 1 << code_width;
    have_prev  = 1'b0;
    prev_code  = 0;
    first_char = '0;
  endfunction

  function automatic void decoder_restart();
    root_bits = (min_size < 2) ? 2 : (min_size > 8) ? 8 : int'(min_size);
    dict_clear();
    bit_buf     = '0;
    bits_held   = 0;
    block_left  = 0;
    stack_depth = 0;
    ended       = 1'b0;
    failed      = 1'b0;
  endfunction

  function automatic void stack_push(int v);
    if (stack_depth < TableSize) begin
      pixel_stack[stack_depth] = v[7:0];
      stack_depth++;
    end
  endfunction

  // Read codes until a pixel lands on the stack or decoding has to stop.
  function automatic logic [2:0] decode_codes();
    int clr_code;
    int first_free;
    int c;
    int code;
    clr_code   = 1 << root_bits;
    first_free = clr_code + 2;
    forever begin
      if (bits_held < code_width) return ST_NEED_BYTE;
      c = int'(bit_buf & ((24'd1 << code_width) - 24'd1));
      bit_buf = bit_buf >> code_width;
      bits_held -= code_width;
      if (c == clr_code + 1) begin
        ended = 1'b1;
        return ST_END;
      end
      if (c == clr_code) begin
        dict_clear();
        continue;
      end
      code = c;
      if (c == next_slot && have_prev) begin
        stack_push(int'(first_char));
        code = prev_code;
      end else if (c >= next_slot) begin
        failed = 1'b1;
        return ST_BAD_CODE;
      end
      while (code >= first_free && stack_depth < TableSize) begin
        stack_push(int'(suffix_mem[code & 12'hfff]));
        code = int'(prefix_mem[code & 12'hfff]);
      end
      code &= 8'hff;
      stack_push(code);
      if (next_slot < slot_limit && have_prev && next_slot < TableSize) begin
        suffix_mem[next_slot] = code[7:0];
        prefix_mem[next_slot] = prev_code[11:0];
        next_slot++;
      end
      first_char = code[7:0];
      prev_code  = c;
      have_prev  = 1'b1;
      if (next_slot >= slot_limit && code_width < MaxCodeBits) begin
        slot_limit = slot_limit << 1;
        code_width++;
      end
      return ST_PIXEL;
    end
  endfunction

  function automatic resp_t predict_response(logic [1:0] act, logic [7:0] b);
    resp_t r;
    r = '0;
    case (act)
      ACT_PUSH: begin
        if (block_left == 0) begin
          block_left = int'(b);
          r.status = ST_ACCEPTED;
        end else if (bits_held >= 16) begin
          r.status = ST_REFUSED;
        end else begin
          bit_buf = bit_buf | (24'(b) << bits_held);
          bits_held += 8;
          block_left--;
          r.status = ST_ACCEPTED;
        end
      end
      ACT_PULL: begin
        if (stack_depth == 0) begin
          if (failed) r.status = ST_BAD_CODE;
          else if (ended) r.status = ST_END;
          else r.status = decode_codes();
        end else begin
          r.status = ST_PIXEL;
        end
        if (r.status == ST_PIXEL && stack_depth > 0) begin
          stack_depth--;
          r.pixel = pixel_stack[stack_depth];
        end
      end
      default: begin
        decoder_restart();
        r.status = ST_RESTARTED;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    resp_t want;
    if (!rst_ni) begin
      resp_q.delete();
      min_size     = 4'd8;
      fail_count_o = 0;
      decoder_restart();
    end else begin
      if (cfg_valid_i && cfg_ready_i) min_size = min_code_size_i;
      // predict first, so a same-edge response still finds its entry
      if (in_valid_i && in_ready_i && action_i != 2'd3)
        resp_q.push_back(predict_response(action_i, data_byte_i));
      if (out_valid_i && out_ready_i) begin
        if (resp_q.size() == 0) begin
          $error("response with nothing expected: pixel %0d status %0d",
                 pixel_i, status_i);
          fail_count_o++;
        end else begin
          want = resp_q.pop_front();
          if (pixel_i !== want.pixel) begin
            $error("pixel: expected %0d, got %0d", want.pixel, pixel_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = resp_q.size();
  end

endmodule

[verif/tb_gif_lzw_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gif_lzw_decoder_top
// Feeds the decoder GIF sub-block streams built from legal random code
// sequences (clears, KwKwK codes, width growth) plus bad codes and random
// noise, under random gaps and output stalls, across several minimum code
// sizes; the checker module judges every response.
// ----------------------------------------------------------------------------
module tb_gif_lzw_decoder_top;
  import gld_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] action = ACT_PUSH;
  logic [7:0] data_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] pixel;
  logic [2:0] status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_size = 4'd8;
  int         fail_count;
  int         pending;

  int         req_count;
  logic       burst;
  int         stall_left = 0;
  int         idle_cycles = 0;

  // code stream generator state
  byte unsigned stream_q[$];
  int         g_root, g_width, g_slot, g_limit;
  logic       g_prev;
  int         acc_bits, acc_len;

  always #5 clk_i = ~clk_i;

  gif_lzw_decoder_top uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .data_byte_i(data_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pixel_o(pixel), .status_o(status),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .min_code_size_i(cfg_size)
  );

  gif_lzw_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .action_i(action), .data_byte_i(data_byte),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .pixel_i(pixel), .status_i(status),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .min_code_size_i(cfg_size),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!burst && $urandom_range(3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("** gif_lzw_decoder_top: FAILED **");
      $finish;
    end
  end

  // Send one request and wait for its response; action 3 gets none.
  task automatic send(input logic [1:0] act, input logic [7:0] b, output logic [2:0] st);
    int   g;
    logic hit;
    g = pick_gap();
    repeat (g) @(posedge clk_i);
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    do begin
      @(negedge clk_i);
      hit = in_ready;
      @(posedge clk_i);
    end while (!hit);
    in_valid <= 1'b0;
    st = ST_ACCEPTED;
    if (act == 2'd3) begin
      @(posedge clk_i);
    end else begin
      req_count++;
      do begin
        @(negedge clk_i);
        hit = out_valid && out_ready;
        st  = status;
        @(posedge clk_i);
      end while (!hit);
    end
  endtask

  task automatic write_size(input logic [3:0] v);
    logic hit;
    logic [2:0] st;
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_size  <= v;
    do begin
      @(negedge clk_i);
      hit = cfg_ready;
      @(posedge clk_i);
    end while (!hit);
    cfg_valid <= 1'b0;
    send(ACT_RESTART, 8'($urandom), st);
  endtask

  // Pull until the stack and decoder stop yielding pixels.
  task automatic drain(output logic [2:0] st);
    do send(ACT_PULL, 8'($urandom), st); while (st == ST_PIXEL);
  endtask

  function automatic void gen_clear();
    g_width = g_root + 1;
    g_slot  = (1 << g_root) + 2;
    g_limit = 1 << g_width;
    g_prev  = 1'b0;
  endfunction

  function automatic void emit(int c);
    acc_bits |= c << acc_len;
    acc_len += g_width;
    while (acc_len >= 8) begin
      stream_q.push_back(acc_bits[7:0]);
      acc_bits >>= 8;
      acc_len -= 8;
    end
  endfunction

  // Build a packed code stream; rates are per thousand.
  function automatic void build_stream(int root, int ncodes, int p_kwk, int p_bad,
                                       int p_root);
    int clr, c;
    stream_q.delete();
    acc_bits = 0;
    acc_len  = 0;
    g_root   = root;
    clr      = 1 << root;
    gen_clear();
    emit(clr);
    for (int i = 0; i < ncodes; i++) begin
      if ($urandom_range(999) < 15) begin
        emit(clr);
        gen_clear();
      end
      if ($urandom_range(999) < p_bad) begin
        // above next slot, or next slot with no previous code, else a clear code
        if (g_slot + 1 < (1 << g_width)) emit(g_slot + 1);
        else if (!g_prev) emit(g_slot);
        else emit(clr);
        if (acc_len > 0) stream_q.push_back(acc_bits[7:0]);
        return;
      end
      if (!g_prev || $urandom_range(999) < p_root || g_slot == clr + 2)
        c = $urandom_range(clr - 1);
      else if ($urandom_range(999) < p_kwk && g_slot < TableSize)
        c = g_slot;
      else
        c = $urandom_range(g_slot - 1, clr + 2);
      emit(c);
      if (g_prev && g_slot < g_limit && g_slot < TableSize) g_slot++;
      g_prev = 1'b1;
      if (g_slot >= g_limit && g_width < MaxCodeBits) begin
        g_limit <<= 1;
        g_width++;
      end
    end
    emit(clr + 1);
    if (acc_len > 0) stream_q.push_back(8'(acc_bits | ($urandom << acc_len)));
  endfunction

  // Push the stream in sub-blocks, pulling pixels whenever the buffer fills.
  task automatic feed_stream(input int max_block);
    logic [2:0] st;
    int idx, len;
    logic stop;
    idx  = 0;
    stop = 1'b0;
    send(ACT_RESTART, 8'($urandom), st);
    while (idx < stream_q.size() && !stop) begin
      if ($urandom_range(19) == 0) send(ACT_PUSH, 8'd0, st);
      len = $urandom_range(max_block, 1);
      if (len > stream_q.size() - idx) len = stream_q.size() - idx;
      send(ACT_PUSH, 8'(len), st);
      for (int k = 0; k < len && !stop; k++) begin
        send(ACT_PUSH, stream_q[idx], st);
        while (st == ST_REFUSED && !stop) begin
          drain(st);
          if (st == ST_END || st == ST_BAD_CODE) stop = 1'b1;
          else send(ACT_PUSH, stream_q[idx], st);
        end
        idx++;
      end
    end
    if (!stop) begin
      send(ACT_PUSH, 8'd0, st);
      drain(st);
    end
    send(ACT_PULL, 8'($urandom), st);
  endtask

  task automatic noise(input int n);
    logic [2:0] st;
    for (int i = 0; i < n; i++)
      send(2'($urandom_range(3)), 8'($urandom), st);
  endtask

  initial begin
    logic [2:0] st;
    logic [3:0] sizes [10] = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd5, 4'd3, 4'd7, 4'd4, 4'd6, 4'd1};
    int root;
    int n;
    req_count   = 0;
    burst       = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ignored action, empty pull, zero length, then small streams
    send(2'd3, 8'hff, st);
    send(ACT_PULL, 8'h00, st);
    send(ACT_PUSH, 8'd0, st);
    send(ACT_PUSH, 8'd255, st);
    send(ACT_PUSH, 8'hff, st);
    send(ACT_PUSH, 8'h00, st);
    send(ACT_PUSH, 8'haa, st);
    send(ACT_PUSH, 8'h55, st);
    send(ACT_RESTART, 8'h00, st);
    build_stream(8, 8, 600, 0, 0);
    feed_stream(4);
    send(ACT_PUSH, 8'd1, st);
    send(ACT_PUSH, 8'h81, st);
    send(ACT_PULL, 8'h00, st);
    build_stream(8, 2, 0, 1000, 0);
    feed_stream(3);
    send(ACT_PULL, 8'h00, st);

    for (int s = 0; req_count < 950; s++) begin
      write_size(sizes[s % 10]);
      root = (sizes[s % 10] < 2) ? 2 : (sizes[s % 10] > 8) ? 8 : int'(sizes[s % 10]);
      for (int j = 0; j < 3; j++) begin
        burst = ($urandom_range(4) == 0);
        n = $urandom_range(40, 4);
        build_stream(root, n, 120, ($urandom_range(5) == 0) ? 40 : 0, 300);
        feed_stream(($urandom_range(3) == 0) ? 255 : 12);
      end
      burst = 1'b0;
      noise($urandom_range(30, 5));
    end

    // longer stream at the smallest root: width grows over several steps
    write_size(4'd2);
    build_stream(2, 60, 20, 0, 850);
    feed_stream(255);

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** gif_lzw_decoder_top: PASSED **");
    end else begin
      $display("** gif_lzw_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
